### hw/rtl/wla_pkg.sv
`default_nettype none

package wla_pkg;

    localparam int WINDOW_DEPTH = 64;

    localparam int SAMPLE_W  = 32;
    localparam int MEAN_W    = 32;
    localparam int HELD_W    = 7;
    localparam int SLOT_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int COUNT_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

endpackage

`default_nettype wire

### hw/rtl/wla_if.sv
`default_nettype none

interface wla_sample_if;
    logic                            valid;
    logic                            ready;
    logic [wla_pkg::SAMPLE_W-1:0]    latency_sample;

    modport source (output valid, output latency_sample, input ready);
    modport sink   (input valid, input latency_sample, output ready);
endinterface

interface wla_mean_if;
    logic                            valid;
    logic                            ready;
    logic [wla_pkg::MEAN_W-1:0]      mean_latency;
    logic [wla_pkg::HELD_W-1:0]      samples_held;

    modport source (output valid, output mean_latency, output samples_held, input ready);
    modport sink   (input valid, input mean_latency, input samples_held, output ready);
endinterface

`default_nettype wire

### hw/rtl/windowed_latency_average.sv
// Channel    Modport   Payload                         Role
// sample_ch  sink      latency_sample[31:0]            one latency sample per transaction
// mean_ch    source    mean_latency[31:0],             moving mean and window fill
//                      samples_held[6:0]
//
// Each sample passes through one ring read, one read-modify-write of the ring
// slot and running sum, the bit-serial divider and a load of the output
// register. The next sample is taken once the result sits in the output
// register, even while mean_ch is stalled. Reset clears the slot pointer,
// fill count and sum at once; the ring needs no clearing.
`default_nettype none

module windowed_latency_average (
    input  wire logic   clk,
    input  wire logic   rst_n,
    wla_sample_if.sink  sample_ch,
    wla_mean_if.source  mean_ch
);

    import wla_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                out_valid_reg, out_valid_next;
    logic [MEAN_W-1:0]   mean_reg;
    logic [HELD_W-1:0]   held_reg;

    logic                in_fire;
    logic                full;
    logic                ram_we;
    logic                ram_re;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic                div_start;
    logic                div_done;
    logic [SUM_W-1:0]    div_quotient;
    logic                out_free;
    logic                load_out;
    logic [SUM_W-1:0]    oldest;

    assign sample_ch.ready = (state_reg == ST_IDLE);
    assign in_fire         = sample_ch.valid && sample_ch.ready;
    assign full            = (count_reg == COUNT_W'(WINDOW_DEPTH));
    assign out_free        = !out_valid_reg || mean_ch.ready;
    assign ram_re          = in_fire;
    assign ram_we          = (state_reg == ST_READ);
    assign div_start       = (state_reg == ST_READ);
    assign oldest          = full ? SUM_W'(ram_rdata) : '0;

    wla_ring_ram #(
        .DEPTH  (WINDOW_DEPTH),
        .WIDTH  (SAMPLE_W),
        .ADDR_W (SLOT_W)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (sample_reg),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    wla_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (count_next),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // drop the oldest sample once the window is full; wraps cancel
                sum_next   = sum_reg + SUM_W'(sample_reg) - oldest;
                count_next = full ? count_reg : count_reg + 1'b1;
                slot_next  = (slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (mean_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg <= sample_ch.latency_sample;
        end
        if (load_out)
        begin
            mean_reg <= div_quotient[MEAN_W-1:0];
            held_reg <= HELD_W'(count_reg);
        end
    end

    assign mean_ch.valid        = out_valid_reg;
    assign mean_ch.mean_latency = mean_reg;
    assign mean_ch.samples_held = held_reg;

endmodule

`default_nettype wire

### hw/rtl/wla_ring_ram.sv
`default_nettype none

module wla_ring_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/wla_divider.sv
`default_nettype none

module wla_divider (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [wla_pkg::SUM_W-1:0]    dividend,
    input  wire logic [wla_pkg::COUNT_W-1:0]  divisor,
    output logic                              done,
    output logic      [wla_pkg::SUM_W-1:0]    quotient
);

    import wla_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]     q_reg, q_next;
    logic [COUNT_W-1:0]   r_reg, r_next;
    logic [COUNT_W-1:0]   d_reg, d_next;
    logic [COUNT_W:0]     trial;
    logic                 fits;

    // one quotient bit per cycle, restoring
    assign trial = {r_reg, q_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(SUM_W);
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[SUM_W-2:0], fits};
            r_next = fits ? COUNT_W'(trial - {1'b0, d_reg}) : trial[COUNT_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

### hw/rtl/wla_checker.sv
`default_nettype none

module wla_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [wla_pkg::MEAN_W-1:0]  mean_latency,
    input wire logic [wla_pkg::HELD_W-1:0]  samples_held
);

    import wla_pkg::*;

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mean_latency) && $stable(samples_held))
        else $error("result changed while stalled");

    // one sample at a time: ready drops right after a transaction
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample taken while previous one in flight");

    // every result reports at least one sample held
    a_held_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> samples_held != '0)
        else $error("result with empty window");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (WINDOW_DEPTH > 127) || (samples_held <= HELD_W'(WINDOW_DEPTH)))
        else $error("window fill exceeds depth");

endmodule

bind windowed_latency_average wla_checker u_wla_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sample_ch.valid),
    .in_ready     (sample_ch.ready),
    .out_valid    (mean_ch.valid),
    .out_ready    (mean_ch.ready),
    .mean_latency (mean_ch.mean_latency),
    .samples_held (mean_ch.samples_held)
);

`default_nettype wire

### bench/windowed_latency_average_test.sv
`default_nettype none

module windowed_latency_average_test;

    timeunit 1ns;
    timeprecision 1ps;

    import wla_pkg::*;

    typedef struct packed {
        logic [MEAN_W-1:0] mean_latency;
        logic [HELD_W-1:0] samples_held;
    } mean_result_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] latency_sample;
        logic                wait_for_drain;
    } sample_item_t;

    typedef enum int {
        RUN_RANDOM,
        RUN_ALL_MAX,
        RUN_SMALL,
        RUN_WALKING_ONE,
        RUN_NEAR_MAX,
        RUN_ALL_ZERO
    } sample_run_t;

    localparam int TARGET_SAMPLES = 1050;
    localparam int TAIL_SAMPLES   = 100;
    localparam int ITEM_CYCLES    = SUM_W + 3;

    logic clk = 1'b0;
    logic rst_n;

    wla_sample_if sample_ch ();
    wla_mean_if   mean_ch ();

    windowed_latency_average u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .mean_ch   (mean_ch)
    );

    always #5 clk = ~clk;

    // Moving-average state mirrored from the block
    logic [SAMPLE_W-1:0] latency_ring [WINDOW_DEPTH];
    int unsigned         ring_slot;
    int unsigned         held_count;
    logic [63:0]         window_total;

    sample_item_t pending_samples [$];
    mean_result_t expected_means [$];

    int unsigned accepted_count;
    int unsigned checked_count;
    int unsigned full_window_count;
    int unsigned error_count;
    int unsigned send_gap_left;
    int unsigned send_idle_pct;
    int unsigned recv_stall_left;
    int unsigned recv_stall_pct;
    sample_item_t next_item;
    mean_result_t oldest_mean;

    function automatic bit in_tail();
        return pending_samples.size() < TAIL_SAMPLES;
    endfunction

    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 5;
            2:       return 25;
            default: return 60;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic predict_mean(input logic [SAMPLE_W-1:0] sample);
        mean_result_t res;
        window_total = window_total + 64'(sample);
        // Once full, drop the oldest sample before overwriting its slot
        if (held_count == WINDOW_DEPTH)
            window_total = window_total - 64'(latency_ring[ring_slot]);
        else
            held_count++;
        latency_ring[ring_slot] = sample;
        ring_slot = (ring_slot == WINDOW_DEPTH - 1) ? 0 : ring_slot + 1;
        res.mean_latency = MEAN_W'(window_total / 64'(held_count));
        res.samples_held = HELD_W'(held_count);
        expected_means.push_back(res);
        if (held_count == WINDOW_DEPTH)
            full_window_count++;
    endtask

    task automatic queue_sample(input logic [SAMPLE_W-1:0] value, input logic drain_first);
        sample_item_t item;
        item.latency_sample = value;
        item.wait_for_drain = drain_first;
        pending_samples.push_back(item);
    endtask

    // Driver: one transaction in flight, held until ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid          <= 1'b0;
            sample_ch.latency_sample <= '0;
            ring_slot      = 0;
            held_count     = 0;
            window_total   = '0;
            accepted_count = 0;
            send_gap_left  = 0;
            send_idle_pct  = 0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                predict_mean(sample_ch.latency_sample);
                accepted_count++;
                if ($urandom_range(0, 39) == 0)
                    send_idle_pct = pick_idle_pct();
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (send_gap_left > 0)
                begin
                    send_gap_left--;
                    sample_ch.valid <= 1'b0;
                end
                else if (pending_samples.size() == 0)
                begin
                    sample_ch.valid <= 1'b0;
                end
                else if (pending_samples[0].wait_for_drain && expected_means.size() != 0)
                begin
                    // Hold until every outstanding mean has come back
                    sample_ch.valid <= 1'b0;
                end
                else if (!in_tail() && $urandom_range(0, 99) < send_idle_pct)
                begin
                    send_gap_left = $urandom_range(0, 17);
                    sample_ch.valid <= 1'b0;
                end
                else
                begin
                    next_item = pending_samples.pop_front();
                    sample_ch.valid          <= 1'b1;
                    sample_ch.latency_sample <= next_item.latency_sample;
                end
            end
        end
    end

    // Monitor: check each result transaction against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_ch.ready   <= 1'b0;
            checked_count   = 0;
            recv_stall_left = 0;
            recv_stall_pct  = 0;
        end
        else
        begin
            if (mean_ch.valid && mean_ch.ready)
            begin
                if (expected_means.size() == 0)
                begin
                    report_mismatch($sformatf("mean %0d held %0d with no sample outstanding",
                                              mean_ch.mean_latency, mean_ch.samples_held));
                end
                else
                begin
                    oldest_mean = expected_means.pop_front();
                    if (mean_ch.mean_latency !== oldest_mean.mean_latency)
                        report_mismatch($sformatf("result %0d mean_latency %0d, expected %0d",
                                                  checked_count, mean_ch.mean_latency,
                                                  oldest_mean.mean_latency));
                    if (mean_ch.samples_held !== oldest_mean.samples_held)
                        report_mismatch($sformatf("result %0d samples_held %0d, expected %0d",
                                                  checked_count, mean_ch.samples_held,
                                                  oldest_mean.samples_held));
                    checked_count++;
                end
                if ($urandom_range(0, 39) == 0)
                    recv_stall_pct = pick_idle_pct();
            end
            if (recv_stall_left > 0)
            begin
                recv_stall_left--;
                mean_ch.ready <= 1'b0;
            end
            else if (!in_tail() && $urandom_range(0, 99) < recv_stall_pct)
            begin
                recv_stall_left = $urandom_range(0, 17);
                mean_ch.ready <= 1'b0;
            end
            else
            begin
                mean_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        sample_run_t run_kind;
        int unsigned run_len;
        int unsigned drain_marks;

        error_count       = 0;
        full_window_count = 0;
        drain_marks       = 0;

        // Directed: empty window, extremes and bit patterns while filling
        queue_sample(32'h0000_0000, 1'b0);
        queue_sample(32'hFFFF_FFFF, 1'b0);
        queue_sample(32'hFFFF_FFFF, 1'b0);
        queue_sample(32'h0000_0001, 1'b0);
        queue_sample(32'h8000_0000, 1'b0);
        queue_sample(32'h7FFF_FFFF, 1'b0);
        queue_sample(32'hAAAA_AAAA, 1'b0);
        queue_sample(32'h5555_5555, 1'b0);
        queue_sample(32'hFFFF_FFFE, 1'b0);
        queue_sample(32'h0000_0000, 1'b0);
        queue_sample(32'h0000_0003, 1'b0);
        queue_sample(32'hFFFF_FFFF, 1'b0);

        while (pending_samples.size() < TARGET_SAMPLES)
        begin
            run_kind = sample_run_t'($urandom_range(0, 5));
            case (run_kind)
                RUN_ALL_MAX, RUN_ALL_ZERO:
                    run_len = $urandom_range(WINDOW_DEPTH - 4, WINDOW_DEPTH + 8);
                default:
                    run_len = $urandom_range(1, 40);
            endcase
            repeat (run_len)
            begin
                // Force a full drain before a couple of samples mid-run
                if (drain_marks < 2 && pending_samples.size() >= 350 * (drain_marks + 1))
                begin
                    drain_marks++;
                    queue_sample($urandom(), 1'b1);
                end
                case (run_kind)
                    RUN_ALL_MAX:     queue_sample(32'hFFFF_FFFF, 1'b0);
                    RUN_ALL_ZERO:    queue_sample(32'h0000_0000, 1'b0);
                    RUN_SMALL:       queue_sample(SAMPLE_W'($urandom_range(0, 15)), 1'b0);
                    RUN_WALKING_ONE: queue_sample(SAMPLE_W'(1) << $urandom_range(0, 31), 1'b0);
                    RUN_NEAR_MAX:    queue_sample(32'hFFFF_FFFF - $urandom_range(0, 255), 1'b0);
                    default:         queue_sample($urandom(), 1'b0);
                endcase
            end
        end

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_samples.size() != 0 || sample_ch.valid)
            @(posedge clk);
        while (expected_means.size() != 0)
            @(posedge clk);
        // Catch any stray result after the last expected one
        repeat (4 * ITEM_CYCLES) @(posedge clk);

        $display("Summary: %0d latency samples accepted, %0d means checked,",
                 accepted_count, checked_count);
        $display("Summary: %0d over a full %0d-deep window, mixed sample runs, %0d mismatches",
                 full_window_count, WINDOW_DEPTH, error_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout: %0d of %0d means still outstanding",
                 expected_means.size(), accepted_count);
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
